// ===== hw/rtl/psa_pkg.sv =====
// ----------------------------------------------------------------------------
// psa_pkg
// Types, widths and datapath commands shared by the phong shading modules.
// ----------------------------------------------------------------------------
`default_nettype none

package psa_pkg;

  localparam int unsigned SQW      = 50;  // square root operand width
  localparam int unsigned LENW     = 25;  // vector length width
  localparam int unsigned DVW      = 44;  // divider remainder width
  localparam int unsigned QW       = 15;  // quotient width
  localparam int unsigned VW       = 24;  // raw vector component width
  localparam int unsigned DIRW     = 17;  // unit direction component width
  localparam int unsigned DTW      = 34;  // dot product width
  localparam int unsigned D14W     = 20;  // scaled dot width
  localparam int unsigned MW       = 33;  // multiplier operand width
  localparam int unsigned SUMW     = 24;  // channel accumulator width
  localparam int unsigned SQRT_STEPS = SQW / 2;
  localparam int unsigned DIV_STEPS  = QW;
  localparam logic [15:0] ONE_Q14  = 16'h4000;
  localparam logic [15:0] LANE_MAX = 16'hFFFF;

  typedef struct packed {
    logic [47:0] surface_point;
    logic [47:0] surface_normal;
    logic [47:0] view_direction;
    logic [47:0] ambient_coeff;
    logic [47:0] diffuse_coeff;
    logic [47:0] specular_coeff;
    logic [7:0]  shininess;
    logic [47:0] light_position;
    logic [47:0] light_intensity;
    logic        last_light;
  } psa_in_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } psa_out_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_SQ,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_STORE,
    OP_DOT_N,
    OP_DOT_V,
    OP_REFL_PREP,
    OP_REFL,
    OP_BASE,
    OP_POW_MUL,
    OP_POW_SQ,
    OP_ACC_A,
    OP_ACC_B,
    OP_ACC_C,
    OP_ACC_D,
    OP_AMB,
    OP_EMIT
  } psa_op_e;

  typedef struct packed {
    psa_op_e    op;
    logic [1:0] lane;
    logic [2:0] pos;
  } psa_cmd_t;

  typedef struct packed {
    logic last_light;
    logic out_free;
  } psa_status_t;

  function automatic logic [15:0] lane_of(logic [47:0] w, logic [1:0] c);
    return w[16*c +: 16];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/psa_ctrl.sv =====
// ----------------------------------------------------------------------------
// psa_ctrl
// Sequencer that steps the shading datapath through one light per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module psa_ctrl import psa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  psa_status_t status_i,
  output logic        in_ready_o,
  output psa_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_SQ, S_SQRT_INIT, S_SQRT, S_DIV_INIT, S_DIV, S_DIV_STORE, S_DOT,
    S_REFL_PREP, S_REFL, S_BASE, S_POW_MUL, S_POW_SQ, S_ACC_A, S_ACC_B,
    S_ACC_C, S_ACC_D, S_AMB, S_EMIT_WAIT, S_EMIT
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] lane_q, lane_d;
  logic [2:0] pos_q, pos_d;
  logic [4:0] iter_q, iter_d;
  logic       pass_q, pass_d;
  logic       in_ready_q;
  psa_cmd_t   cmd_q;

  function automatic psa_op_e op_of(state_e s, logic p);
    psa_op_e o;
    case (s)
      S_SQ:        o = OP_SQ;
      S_SQRT_INIT: o = OP_SQRT_INIT;
      S_SQRT:      o = OP_SQRT_STEP;
      S_DIV_INIT:  o = OP_DIV_INIT;
      S_DIV:       o = OP_DIV_STEP;
      S_DIV_STORE: o = OP_DIV_STORE;
      S_DOT:       o = p ? OP_DOT_V : OP_DOT_N;
      S_REFL_PREP: o = OP_REFL_PREP;
      S_REFL:      o = OP_REFL;
      S_BASE:      o = OP_BASE;
      S_POW_MUL:   o = OP_POW_MUL;
      S_POW_SQ:    o = OP_POW_SQ;
      S_ACC_A:     o = OP_ACC_A;
      S_ACC_B:     o = OP_ACC_B;
      S_ACC_C:     o = OP_ACC_C;
      S_ACC_D:     o = OP_ACC_D;
      S_AMB:       o = OP_AMB;
      S_EMIT:      o = OP_EMIT;
      default:     o = OP_NONE;
    endcase
    return o;
  endfunction

  always_comb begin
    state_d = state_q;
    lane_d  = lane_q;
    pos_d   = pos_q;
    iter_d  = iter_q;
    pass_d  = pass_q;
    case (state_q)
      S_IDLE: begin
        if (load_i) begin
          state_d = S_SQ;
          lane_d  = 2'd0;
          pass_d  = 1'b0;
        end
      end
      S_SQ: begin
        if (lane_q == 2'd2) begin
          state_d = S_SQRT_INIT;
        end else begin
          lane_d = lane_q + 2'd1;
        end
      end
      S_SQRT_INIT: begin
        state_d = S_SQRT;
        iter_d  = '0;
      end
      S_SQRT: begin
        if (iter_q == 5'(SQRT_STEPS - 1)) begin
          state_d = S_DIV_INIT;
          lane_d  = 2'd0;
        end else begin
          iter_d = iter_q + 5'd1;
        end
      end
      S_DIV_INIT: begin
        state_d = S_DIV;
        iter_d  = '0;
      end
      S_DIV: begin
        if (iter_q == 5'(DIV_STEPS - 1)) begin
          state_d = S_DIV_STORE;
        end else begin
          iter_d = iter_q + 5'd1;
        end
      end
      S_DIV_STORE: begin
        if (lane_q == 2'd2) begin
          state_d = S_DOT;
          lane_d  = 2'd0;
        end else begin
          state_d = S_DIV_INIT;
          lane_d  = lane_q + 2'd1;
        end
      end
      S_DOT: begin
        if (lane_q == 2'd2) begin
          state_d = pass_q ? S_BASE : S_REFL_PREP;
        end else begin
          lane_d = lane_q + 2'd1;
        end
      end
      S_REFL_PREP: begin
        state_d = S_REFL;
        lane_d  = 2'd0;
      end
      S_REFL: begin
        if (lane_q == 2'd2) begin
          state_d = S_SQ;
          lane_d  = 2'd0;
          pass_d  = 1'b1;
        end else begin
          lane_d = lane_q + 2'd1;
        end
      end
      S_BASE: begin
        state_d = S_POW_MUL;
        pos_d   = '0;
      end
      S_POW_MUL: state_d = S_POW_SQ;
      S_POW_SQ: begin
        if (pos_q == 3'd7) begin
          state_d = S_ACC_A;
          lane_d  = 2'd0;
        end else begin
          state_d = S_POW_MUL;
          pos_d   = pos_q + 3'd1;
        end
      end
      S_ACC_A: state_d = S_ACC_B;
      S_ACC_B: state_d = S_ACC_C;
      S_ACC_C: state_d = S_ACC_D;
      S_ACC_D: begin
        if (lane_q != 2'd2) begin
          state_d = S_ACC_A;
          lane_d  = lane_q + 2'd1;
        end else if (status_i.last_light) begin
          state_d = S_AMB;
          lane_d  = 2'd0;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_AMB: begin
        if (lane_q == 2'd2) begin
          state_d = S_EMIT_WAIT;
        end else begin
          lane_d = lane_q + 2'd1;
        end
      end
      S_EMIT_WAIT: begin
        if (status_i.out_free) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      lane_q     <= '0;
      pos_q      <= '0;
      iter_q     <= '0;
      pass_q     <= 1'b0;
      in_ready_q <= 1'b0;
      cmd_q      <= '{op: OP_NONE, lane: 2'd0, pos: 3'd0};
    end else begin
      state_q    <= state_d;
      lane_q     <= lane_d;
      pos_q      <= pos_d;
      iter_q     <= iter_d;
      pass_q     <= pass_d;
      in_ready_q <= (state_d == S_IDLE);
      cmd_q      <= '{op: op_of(state_d, pass_d), lane: lane_d, pos: pos_d};
    end
  end

  assign in_ready_o = in_ready_q;
  assign cmd_o      = cmd_q;

endmodule

`default_nettype wire

// ===== hw/rtl/psa_datapath.sv =====
// ----------------------------------------------------------------------------
// psa_datapath
// Shared multiplier, square root and divider with the shading registers.
// ----------------------------------------------------------------------------
`default_nettype none

module psa_datapath import psa_pkg::*; #(
  parameter int unsigned MAX_LIGHTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  psa_in_t     in_data_i,
  input  logic        cfg_we_i,
  input  logic [47:0] cfg_data_i,
  input  psa_cmd_t    cmd_i,
  output psa_status_t status_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output psa_out_t    out_data_o
);

  localparam int unsigned CW = $clog2(MAX_LIGHTS + 1);

  psa_in_t                 item_q;
  logic signed [VW-1:0]    vec_q [3];
  logic signed [DIRW-1:0]  dir_q [3];
  logic [SQW-1:0]          sumsq_q, sq_v_q, sq_r_q, sq_bit_q;
  logic [DVW-1:0]          rem_q, dvs_q;
  logic [QW-1:0]           quo_q;
  logic                    neg_q;
  logic signed [DTW-1:0]   dot_q;
  logic signed [D14W-1:0]  d14_q;
  logic [15:0]             diff_q, base_q, spec_q;
  logic [31:0]             prod_q;
  logic [16:0]             term_q;
  logic [15:0]             res_q [3];
  logic [SUMW-1:0]         sum_q [3];
  logic [CW-1:0]           cnt_q;
  logic [47:0]             amb_q;
  psa_out_t                out_q;
  logic                    out_valid_q;

  logic signed [15:0]      nv, vv;
  logic [15:0]             kd, ks, it, ka, al;
  logic signed [VW-1:0]    vec_sel;
  logic signed [DIRW-1:0]  dir_sel;
  logic [SUMW-1:0]         sum_sel;
  logic signed [MW-1:0]    mul_a, mul_b;
  logic signed [2*MW-1:0]  prod;
  logic [15:0]             qsat;
  logic [SQW-1:0]          rb;
  logic signed [39:0]      rt, rtr;
  logic signed [DTW-1:0]   dtr;
  logic [VW-1:0]           mag;
  logic [25:0]             acc_s, amb_s;
  logic                    zero_len, room;

  function automatic logic [15:0] clamp_q14(logic signed [DTW-1:0] d);
    logic signed [DTW-1:0] q;
    q = d >>> 14;
    if (d <= 0) begin
      return 16'd0;
    end else if (q > DTW'(LANE_MAX)) begin
      return LANE_MAX;
    end
    return q[15:0];
  endfunction

  assign nv      = signed'(lane_of(item_q.surface_normal, cmd_i.lane));
  assign vv      = signed'(lane_of(item_q.view_direction, cmd_i.lane));
  assign kd      = lane_of(item_q.diffuse_coeff, cmd_i.lane);
  assign ks      = lane_of(item_q.specular_coeff, cmd_i.lane);
  assign it      = lane_of(item_q.light_intensity, cmd_i.lane);
  assign ka      = lane_of(item_q.ambient_coeff, cmd_i.lane);
  assign al      = lane_of(amb_q, cmd_i.lane);
  assign vec_sel = vec_q[cmd_i.lane];
  assign dir_sel = dir_q[cmd_i.lane];
  assign sum_sel = sum_q[cmd_i.lane];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_SQ: begin
        mul_a = MW'(vec_sel);
        mul_b = MW'(vec_sel);
      end
      OP_DOT_N: begin
        mul_a = MW'(nv);
        mul_b = MW'(dir_sel);
      end
      OP_DOT_V: begin
        mul_a = MW'(vv);
        mul_b = MW'(dir_sel);
      end
      OP_REFL: begin
        mul_a = MW'(d14_q);
        mul_b = MW'(nv);
      end
      OP_POW_MUL: begin
        mul_a = MW'({1'b0, spec_q});
        mul_b = MW'({1'b0, base_q});
      end
      OP_POW_SQ: begin
        mul_a = MW'({1'b0, base_q});
        mul_b = MW'({1'b0, base_q});
      end
      OP_ACC_A: begin
        mul_a = MW'({1'b0, kd});
        mul_b = MW'({1'b0, it});
      end
      OP_ACC_B: begin
        mul_a = MW'({1'b0, prod_q});
        mul_b = MW'({1'b0, diff_q});
      end
      OP_ACC_C: begin
        mul_a = MW'({1'b0, ks});
        mul_b = MW'({1'b0, it});
      end
      OP_ACC_D: begin
        mul_a = MW'({1'b0, prod_q});
        mul_b = MW'({1'b0, spec_q});
      end
      OP_AMB: begin
        mul_a = MW'({1'b0, ka});
        mul_b = MW'({1'b0, al});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign qsat     = (|prod[2*MW-1:30]) ? LANE_MAX : prod[29:14];
  assign rb       = sq_r_q + sq_bit_q;
  assign rt       = (40'(prod) <<< 1) - (40'(dir_sel) <<< 14);
  assign rtr      = rt + (rt[39] ? 40'sd16383 : 40'sd0);
  assign dtr      = dot_q + (dot_q[DTW-1] ? DTW'(16383) : DTW'(0));
  assign mag      = vec_sel[VW-1] ? VW'(-vec_sel) : VW'(vec_sel);
  assign acc_s    = 26'(sum_sel) + 26'(term_q) + 26'(prod[48:32]);
  assign amb_s    = 26'(prod[33:18]) + 26'(sum_sel);
  assign zero_len = (sumsq_q == '0);
  assign room     = (cnt_q < CW'(MAX_LIGHTS));

  // working registers
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= in_data_i;
      for (int c = 0; c < 3; c++) begin
        vec_q[c] <= VW'(signed'(lane_of(in_data_i.light_position, 2'(c))))
                  - VW'(signed'(lane_of(in_data_i.surface_point, 2'(c))));
      end
    end
    case (cmd_i.op)
      OP_SQ: begin
        sumsq_q <= ((cmd_i.lane == 2'd0) ? '0 : sumsq_q) + SQW'(prod);
      end
      OP_SQRT_INIT: begin
        sq_v_q   <= sumsq_q << 8;
        sq_r_q   <= '0;
        sq_bit_q <= SQW'(1) << (SQW - 2);
      end
      OP_SQRT_STEP: begin
        if (sq_v_q >= rb) begin
          sq_v_q <= sq_v_q - rb;
          sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
        end else begin
          sq_r_q <= sq_r_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
      end
      OP_DIV_INIT: begin
        rem_q <= DVW'(mag) << 18;
        dvs_q <= DVW'(sq_r_q[LENW-1:0]) << (QW - 1);
        quo_q <= '0;
        neg_q <= vec_sel[VW-1];
      end
      OP_DIV_STEP: begin
        if (rem_q >= dvs_q) begin
          rem_q <= rem_q - dvs_q;
          quo_q <= {quo_q[QW-2:0], 1'b1};
        end else begin
          quo_q <= {quo_q[QW-2:0], 1'b0};
        end
        dvs_q <= dvs_q >> 1;
      end
      OP_DIV_STORE: begin
        if (zero_len) begin
          dir_q[cmd_i.lane] <= '0;
        end else if (neg_q) begin
          dir_q[cmd_i.lane] <= -DIRW'(quo_q);
        end else begin
          dir_q[cmd_i.lane] <= DIRW'(quo_q);
        end
      end
      OP_DOT_N, OP_DOT_V: begin
        dot_q <= ((cmd_i.lane == 2'd0) ? '0 : dot_q) + DTW'(prod);
      end
      OP_REFL_PREP: begin
        diff_q <= clamp_q14(dot_q);
        d14_q  <= D14W'(dtr >>> 14);
      end
      OP_REFL: vec_q[cmd_i.lane] <= VW'(rtr >>> 14);
      OP_BASE: begin
        base_q <= clamp_q14(dot_q);
        spec_q <= ONE_Q14;
      end
      OP_POW_MUL: begin
        if (item_q.shininess[cmd_i.pos]) begin
          spec_q <= qsat;
        end
      end
      OP_POW_SQ: base_q <= qsat;
      OP_ACC_A, OP_ACC_C: prod_q <= prod[31:0];
      OP_ACC_B: term_q <= prod[48:32];
      OP_AMB: res_q[cmd_i.lane] <= (amb_s > 26'(LANE_MAX)) ? LANE_MAX : amb_s[15:0];
      OP_EMIT: out_q <= '{red: res_q[0], green: res_q[1], blue: res_q[2]};
      default: ;
    endcase
  end

  // accumulators, light count, ambient register and output flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 3; c++) begin
        sum_q[c] <= '0;
      end
      cnt_q       <= '0;
      amb_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        amb_q <= cfg_data_i;
      end
      if (cmd_i.op == OP_ACC_D && room) begin
        sum_q[cmd_i.lane] <= (acc_s > 26'({SUMW{1'b1}})) ? {SUMW{1'b1}}
                                                        : acc_s[SUMW-1:0];
        if (cmd_i.lane == 2'd2) begin
          cnt_q <= cnt_q + CW'(1);
        end
      end
      if (cmd_i.op == OP_AMB) begin
        sum_q[cmd_i.lane] <= '0;
        cnt_q             <= '0;
      end
      if (cmd_i.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o    = '{last_light: item_q.last_light,
                         out_free: !out_valid_q || out_ready_i};
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/phong_shading_accumulator.sv =====
// ----------------------------------------------------------------------------
// phong_shading_accumulator
// Phong shading of one surface point over a group of lights, fixed point.
// ----------------------------------------------------------------------------
// One input transaction is one light for one point: two vector
// normalizations each run a bit-pair square root and a restoring divide per
// component, and every product goes through one shared 33x33 multiplier.
// The light that closes a group goes on to the ambient term and the result,
// which then sits in an output register while the next light is already
// accepted. Lights beyond MAX_LIGHTS in a group are ignored but a closing
// light still emits.
// ----------------------------------------------------------------------------
`default_nettype none

module phong_shading_accumulator import psa_pkg::*; #(
  parameter int unsigned MAX_LIGHTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [47:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  psa_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output psa_out_t    out_data_o
);

  psa_cmd_t    cmd;
  psa_status_t status;
  logic        load;

  assign cfg_ready_o = 1'b1;
  assign load        = in_valid_i && in_ready_o;

  psa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  psa_datapath #(
    .MAX_LIGHTS (MAX_LIGHTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/psa_checker.sv =====
// ----------------------------------------------------------------------------
// psa_checker
// Port-level checks on the shading block's handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module psa_checker import psa_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_o,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire psa_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before its transaction");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a light is in work");

  a_emit_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a light in work");

endmodule

bind phong_shading_accumulator psa_checker u_psa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the phong shading accumulator: directed and random
// light groups are driven through the input channel, an internal fixed-point
// shading predictor builds the expected colours, and a monitor compares every
// emitted colour with the oldest prediction under varied back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import psa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIGHTS_PER_GROUP = 16;
  localparam int unsigned IDLE_LIMIT       = 20000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     cfg_valid_i = 1'b0;
  logic     cfg_ready_o;
  logic [47:0] cfg_data_i = '0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  psa_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  psa_out_t out_data_o;

  always #4 clk_i = ~clk_i;

  phong_shading_accumulator #(.MAX_LIGHTS(LIGHTS_PER_GROUP)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  // shading predictor state
  logic [47:0] amb_light;
  logic [23:0] colour_sum [3];
  int unsigned lights_seen;

  psa_in_t  light_queue [$];
  psa_out_t colour_queue [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int unsigned mismatches = 0;
  int unsigned colours_checked = 0;
  int unsigned lights_sent = 0;
  int unsigned idle_cycles = 0;

  function automatic longint sgn(logic [47:0] w, int c);
    return longint'($signed(w[16*c +: 16]));
  endfunction

  function automatic longint unsigned usq(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic unit_vec(input longint a [3], output longint o [3]);
    longint unsigned s, len, m, q;
    s = 0;
    for (int i = 0; i < 3; i++) s += longint'(a[i] * a[i]);
    if (s == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
    end else begin
      len = usq(s << 8);
      for (int i = 0; i < 3; i++) begin
        m = a[i] < 0 ? -a[i] : a[i];
        q = (m << 18) / len;
        o[i] = a[i] < 0 ? -longint'(q) : longint'(q);
      end
    end
  endtask

  function automatic longint unsigned clamp14(longint d);
    longint unsigned q;
    if (d <= 0) return 0;
    q = d / 16384;
    return q > 65535 ? 65535 : q;
  endfunction

  function automatic longint unsigned fmul(longint unsigned a, longint unsigned b);
    longint unsigned p;
    p = (a * b) >> 14;
    return p > 65535 ? 65535 : p;
  endfunction

  task automatic shade_light(input psa_in_t t);
    longint lv [3], ld [3], nv [3], vv [3], rv [3], rd [3];
    longint nd, d14, vr;
    longint unsigned diff, base, spec, inten, td, ts, s, amb, tot;
    psa_out_t res;
    for (int c = 0; c < 3; c++) begin
      lv[c] = sgn(t.light_position, c) - sgn(t.surface_point, c);
      nv[c] = sgn(t.surface_normal, c);
      vv[c] = sgn(t.view_direction, c);
    end
    unit_vec(lv, ld);
    nd = nv[0] * ld[0] + nv[1] * ld[1] + nv[2] * ld[2];
    diff = clamp14(nd);
    d14 = nd / 16384;
    for (int c = 0; c < 3; c++) rv[c] = (2 * d14 * nv[c] - ld[c] * 16384) / 16384;
    unit_vec(rv, rd);
    vr = vv[0] * rd[0] + vv[1] * rd[1] + vv[2] * rd[2];
    base = clamp14(vr);
    spec = 16384;
    for (int k = 0; k < 8; k++) begin
      if (t.shininess[k]) spec = fmul(spec, base);
      base = fmul(base, base);
    end
    if (lights_seen < LIGHTS_PER_GROUP) begin
      for (int c = 0; c < 3; c++) begin
        inten = t.light_intensity[16*c +: 16];
        td = (longint'(t.diffuse_coeff[16*c +: 16]) * inten * diff) >> 32;
        ts = (longint'(t.specular_coeff[16*c +: 16]) * inten * spec) >> 32;
        s = colour_sum[c] + td + ts;
        colour_sum[c] = s > 24'hFFFFFF ? 24'hFFFFFF : s[23:0];
      end
      lights_seen++;
    end
    if (t.last_light) begin
      for (int c = 0; c < 3; c++) begin
        amb = (longint'(t.ambient_coeff[16*c +: 16]) * amb_light[16*c +: 16]) >> 18;
        tot = amb + colour_sum[c];
        tot = tot > 65535 ? 65535 : tot;
        if (c == 0) res.red = tot[15:0];
        else if (c == 1) res.green = tot[15:0];
        else res.blue = tot[15:0];
        colour_sum[c] = '0;
      end
      lights_seen = 0;
      colour_queue.push_back(res);
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      shade_light(in_data_i);
      lights_sent++;
    end
    if (!in_valid_i || in_ready_o) begin
      if (light_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i <= light_queue.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (colour_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected colour %h", out_data_o);
      end else begin
        psa_out_t exp_c;
        exp_c = colour_queue.pop_front();
        colours_checked++;
        if (exp_c.red !== out_data_o.red || exp_c.green !== out_data_o.green ||
            exp_c.blue !== out_data_o.blue) begin
          mismatches++;
          if (mismatches <= 10)
            $display("colour mismatch: expected r %h g %h b %h, got r %h g %h b %h",
                     exp_c.red, exp_c.green, exp_c.blue,
                     out_data_o.red, out_data_o.green, out_data_o.blue);
        end
      end
    end
    out_ready_i <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("phong_shading_accumulator verification failed");
      $finish;
    end
  end

  function automatic logic [47:0] rnd48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [47:0] rnd_dir();
    logic [47:0] w;
    for (int c = 0; c < 3; c++) w[16*c +: 16] = 16'($signed($urandom_range(32768)) - 16384);
    return w;
  endfunction

  function automatic psa_in_t rnd_light(bit last);
    psa_in_t t;
    bit wild;
    wild = ($urandom_range(9) == 0);
    t.surface_point   = wild ? rnd48() : {3{16'($urandom_range(4095)) - 16'd2048}};
    t.light_position  = wild ? rnd48() : rnd48() >> ($urandom_range(3) * 4);
    t.surface_normal  = wild ? rnd48() : rnd_dir();
    t.view_direction  = wild ? rnd48() : rnd_dir();
    t.ambient_coeff   = rnd48();
    t.diffuse_coeff   = rnd48();
    t.specular_coeff  = rnd48();
    t.light_intensity = rnd48();
    t.shininess       = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(16));
    t.last_light      = last;
    if ($urandom_range(30) == 0) t.light_position = t.surface_point;
    return t;
  endfunction

  task automatic drain();
    while (light_queue.size() != 0 || in_valid_i || colour_queue.size() != 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_ambient(logic [47:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    amb_light = v;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_groups(int unsigned n_lights);
    int unsigned left, g;
    left = n_lights;
    while (left > 0) begin
      g = ($urandom_range(19) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 4);
      if (g > left) g = left;
      for (int i = 1; i <= g; i++) light_queue.push_back(rnd_light(i == g));
      left -= g;
    end
  endtask

  initial begin
    psa_in_t t;
    logic [47:0] amb_set [4];
    amb_light = '0;
    lights_seen = 0;
    for (int c = 0; c < 3; c++) colour_sum[c] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, coincident light, zero exponent, oversized group
    write_ambient(48'hFFFF_FFFF_FFFF);
    t = '0;
    t.last_light = 1'b1;
    light_queue.push_back(t);
    t = '1;
    light_queue.push_back(t);
    t = rnd_light(1'b1);
    t.light_position = t.surface_point;
    t.shininess = 8'd0;
    light_queue.push_back(t);
    t = rnd_light(1'b1);
    t.surface_normal = 48'h0000_4000_0000;
    t.view_direction = 48'h0000_4000_0000;
    t.surface_point = '0;
    t.light_position = 48'h0000_0400_0000;
    t.shininess = 8'd0;
    light_queue.push_back(t);
    t.shininess = 8'd255;
    light_queue.push_back(t);
    t.surface_normal = 48'h8000_8000_8000;
    t.view_direction = 48'h7FFF_7FFF_7FFF;
    light_queue.push_back(t);
    for (int i = 1; i <= 18; i++) light_queue.push_back(rnd_light(i == 18));
    drain();

    amb_set[0] = '0;
    amb_set[1] = rnd48();
    amb_set[2] = 48'h8000_8000_8000;
    amb_set[3] = 48'hFFFF_FFFF_FFFF;
    for (int ph = 0; ph < 4; ph++) begin
      write_ambient(amb_set[ph]);
      send_idle_pct = (ph == 1 || ph == 3) ? 76 : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 23 : 76) : 0;
      if (ph == 3) send_idle_pct = 23;
      queue_groups(420);
      if (ph == 0) begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      drain();
    end

    $display("shaded %0d lights into %0d checked colours over four ambient settings",
             lights_sent, colours_checked);
    if (mismatches == 0 && colour_queue.size() == 0) begin
      $display("phong_shading_accumulator verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("phong_shading_accumulator verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
